// ===== sv/slr_pkg.sv =====
// shared types and constants for the spectrum linear rebin block
// no dependencies
`default_nettype none
package slr_pkg;

   localparam int ValueWidth = 32;
   localparam int FluxWidth  = 48;
   localparam int RegIndexLastGrid = 0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_SCAN,
      ST_FETCH_LO,
      ST_FETCH_HI,
      ST_PREP,
      ST_MUL,
      ST_DIV,
      ST_SUM,
      ST_WIDTH,
      ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;    // latch bin item
      logic load;       // write grid point
      logic rd_ptr;     // read at search pointer
      logic rd_lower;   // read at upper-1
      logic rd_upper;   // read at upper
      logic step;       // advance scan pointer
      logic prep;       // differences and signs
      logic mul;        // partial product step
      logic div_start;
      logic div_step;
      logic sum;
      logic width_mul;
      logic finish;     // compute result, update pointer
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_go;    // pointer in range and energy below midpoint
      logic bracket_ok;
      logic trivial;    // interpolation collapses to f0
      logic mul_done;
      logic div_done;
   } status_type;

endpackage
`default_nettype wire

// ===== sv/spectrum_linear_rebin_core.sv =====
// Spectrum linear rebin core: load beats (action 0) write one grid point;
// bin beats scan from the saved search pointer, with a registered store read
// for each grid point stepped over, then fetch the bracket, multiply in two
// 17-bit slices and run a bit-serial divider. Out-of-grid bins skip the
// arithmetic. One item is in work at a time; the result register lets the
// next item enter while a result waits. Registers: last_grid_index at byte
// address 0.
// top level; depends on slr_pkg, slr_ctrl, slr_dpath, slr_ram
`default_nettype none
module spectrum_linear_rebin_core
   import slr_pkg::*;
#(
   parameter int GRID_DEPTH = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_action,
   input  wire logic [7:0]  req_grid_index,
   input  wire logic [31:0] req_grid_energy_in,
   input  wire logic [31:0] req_grid_flux_in,
   input  wire logic [31:0] req_low_edge,
   input  wire logic [31:0] req_high_edge,
   input  wire logic        req_last_bin,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [47:0]      rsp_bin_flux,
   output logic             rsp_out_of_grid,
   output logic             rsp_run_end,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [1:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   cmd_type    cmd;
   status_type status;
   logic [7:0] lgi_ff;

   // register port
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) lgi_ff <= 8'd1;
      else if (csr_psel && csr_penable && csr_pwrite
               && csr_paddr == 2'(RegIndexLastGrid * 4))
         lgi_ff <= csr_pwdata[7:0];
   end
   assign csr_prdata = (csr_paddr == 2'(RegIndexLastGrid * 4)) ? {24'd0, lgi_ff} : 32'd0;

   slr_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_action,
      .rsp_valid, .rsp_ready, .status, .cmd);

   slr_dpath #(.GridDepth(GRID_DEPTH)) u_dpath (
      .clock, .reset, .cmd, .status, .last_grid_index(lgi_ff),
      .req_grid_index, .req_grid_energy_in, .req_grid_flux_in,
      .req_low_edge, .req_high_edge, .req_last_bin,
      .rsp_bin_flux, .rsp_out_of_grid, .rsp_run_end);
endmodule
`default_nettype wire

// ===== sv/slr_ram.sv =====
// generic single port ram with registered read
// no dependencies
`default_nettype none
module slr_ram #(
   parameter int Width = 32,
   parameter int Depth = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wr_data,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule
`default_nettype wire

// ===== sv/slr_ctrl.sv =====
// controller state machine for the rebin block
// depends on slr_pkg
`default_nettype none
module slr_ctrl
   import slr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_action,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type status,
   output cmd_type         cmd
);
   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      out_valid_in = out_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (req_action) begin
                  cmd.rd_ptr = 1'b1;
                  state_in   = ST_READ;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         ST_READ: state_in = ST_SCAN;
         ST_SCAN: begin
            if (status.scan_go) begin
               cmd.step = 1'b1;
               state_in = ST_READ;
            end else if (status.bracket_ok) begin
               cmd.rd_lower = 1'b1;
               state_in     = ST_FETCH_LO;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_FETCH_LO: begin
            cmd.rd_upper = 1'b1;
            state_in     = ST_FETCH_HI;
         end
         ST_FETCH_HI: state_in = ST_PREP;
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (status.trivial) begin
               state_in = ST_SUM;
            end else begin
               cmd.mul = 1'b1;
               if (status.mul_done) begin
                  cmd.div_start = 1'b1;
                  state_in      = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_WIDTH;
         end
         ST_WIDTH: begin
            cmd.width_mul = 1'b1;
            state_in      = ST_OUT;
         end
         ST_OUT: begin
            if (!out_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// ===== sv/slr_dpath.sv =====
// datapath: grid stores, search pointer, interpolation and width product
// depends on slr_pkg and slr_ram
`default_nettype none
module slr_dpath
   import slr_pkg::*;
#(
   parameter int GridDepth = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output status_type       status,
   input  wire logic [7:0]  last_grid_index,
   input  wire logic [7:0]  req_grid_index,
   input  wire logic [31:0] req_grid_energy_in,
   input  wire logic [31:0] req_grid_flux_in,
   input  wire logic [31:0] req_low_edge,
   input  wire logic [31:0] req_high_edge,
   input  wire logic        req_last_bin,
   output logic [47:0]      rsp_bin_flux,
   output logic             rsp_out_of_grid,
   output logic             rsp_run_end
);
   localparam int AW = $clog2(GridDepth);
   localparam int PW = AW + 1;
   localparam logic [PW-1:0] TopMax = PW'(GridDepth - 1);

   // captured bin
   logic [31:0] lo_ff, hi_ff;
   logic        last_ff;
   logic [32:0] m2;
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         lo_ff   <= req_low_edge;
         hi_ff   <= req_high_edge;
         last_ff <= req_last_bin;
      end
   end
   assign m2 = {1'b0, lo_ff} + {1'b0, hi_ff};

   // effective last index
   logic [PW-1:0] top;
   always_comb begin
      if ({{(PW > 8 ? PW-8 : 1){1'b0}}, last_grid_index} > {1'b0, TopMax})
         top = TopMax;
      else
         top = PW'(last_grid_index);
   end

   // search pointer and scan index
   logic [PW-1:0] sp_ff, sp_in, j_ff, j_in;
   always_ff @(posedge clock) begin
      if (reset) sp_ff <= '0;
      else       sp_ff <= sp_in;
      j_ff <= j_in;
   end

   // stores
   logic          load_en;
   logic [AW-1:0] addr;
   logic [31:0]   e_rd, f_rd;
   assign load_en = cmd.load && ({{(PW > 8 ? PW-8 : 1){1'b0}}, req_grid_index}
                                 < PW'(GridDepth));
   always_comb begin
      if (cmd.load)          addr = AW'(req_grid_index);
      else if (cmd.rd_ptr)   addr = sp_ff[AW-1:0];
      else if (cmd.step)     addr = AW'(j_ff + 1'b1);
      else if (cmd.rd_lower) addr = AW'(j_ff - 1'b1);
      else                   addr = j_ff[AW-1:0];
   end
   slr_ram #(.Width(32), .Depth(GridDepth)) u_energy (
      .clock, .wr_en(load_en), .addr, .wr_data(req_grid_energy_in), .rd_data(e_rd));
   slr_ram #(.Width(32), .Depth(GridDepth)) u_flux (
      .clock, .wr_en(load_en), .addr, .wr_data(req_grid_flux_in), .rd_data(f_rd));

   always_comb begin
      j_in = j_ff;
      if (cmd.rd_ptr)    j_in = sp_ff;
      else if (cmd.step) j_in = j_ff + 1'b1;
   end

   assign status.scan_go    = (j_ff <= top) && ({e_rd, 1'b0} < m2);
   assign status.bracket_ok = (j_ff >= PW'(2)) && (j_ff <= top);

   // bracket values: lower arrives the cycle before upper
   logic [31:0] e0_ff, f0_ff, e1_ff, f1_ff;
   logic        fetch_hi_ff;
   always_ff @(posedge clock) begin
      fetch_hi_ff <= cmd.rd_upper;
      if (cmd.rd_upper) begin
         e0_ff <= e_rd;
         f0_ff <= f_rd;
      end
      if (fetch_hi_ff) begin
         e1_ff <= e_rd;
         f1_ff <= f_rd;
      end
   end

   // magnitudes and sign of the correction
   logic [33:0] dt_s, dd_s;
   logic [32:0] df_s;
   logic [32:0] a_ff;
   logic [33:0] b_ff, d_ff;
   logic        neg_ff, triv_ff;
   assign dt_s = {1'b0, m2} - {1'b0, e0_ff, 1'b0};
   assign dd_s = {1'b0, e1_ff, 1'b0} - {1'b0, e0_ff, 1'b0};
   assign df_s = {1'b0, f1_ff} - {1'b0, f0_ff};
   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         a_ff    <= df_s[32] ? 33'(-df_s) : df_s;
         b_ff    <= dt_s[33] ? 34'(-dt_s) : dt_s;
         d_ff    <= dd_s[33] ? 34'(-dd_s) : dd_s;
         neg_ff  <= df_s[32] ^ dt_s[33] ^ dd_s[33];
         triv_ff <= (dt_s == '0) || (dd_s == '0) || (df_s == '0);
      end
   end
   assign status.trivial = triv_ff;

   // product a*b in two 17-bit slices of b
   logic [66:0] prod_ff;
   logic        mcnt_ff;
   logic [49:0] pp;
   assign pp = {17'd0, a_ff} * {33'd0, (mcnt_ff ? b_ff[33:17] : b_ff[16:0])};
   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         prod_ff <= '0;
         mcnt_ff <= 1'b0;
      end else if (cmd.mul) begin
         mcnt_ff <= 1'b1;
         if (mcnt_ff) prod_ff <= prod_ff + {pp, 17'd0};
         else         prod_ff <= prod_ff + 67'(pp);
      end
   end
   assign status.mul_done = mcnt_ff;

   // restoring division, one bit a cycle; quotient saturated at 2^40
   logic [66:0] num_ff;
   logic [33:0] rem_ff;
   logic [40:0] q_ff;
   logic [6:0]  dcnt_ff;
   logic [34:0] rsh, rsub;
   assign rsh  = {rem_ff, num_ff[66]};
   assign rsub = rsh - {1'b0, d_ff};
   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         num_ff  <= prod_ff + {pp, 17'd0};
         rem_ff  <= '0;
         q_ff    <= '0;
         dcnt_ff <= 7'd66;
      end else if (cmd.div_step) begin
         num_ff  <= {num_ff[65:0], 1'b0};
         rem_ff  <= rsub[34] ? rsh[33:0] : rsub[33:0];
         dcnt_ff <= dcnt_ff - 1'b1;
         if (!q_ff[40]) q_ff <= {q_ff[39:0], !rsub[34]};
      end
   end
   assign status.div_done = (dcnt_ff == '0);

   // interpolated flux with saturation
   logic [31:0] flux_ff;
   logic [41:0] fsum;
   assign fsum = {10'd0, f0_ff} + {1'b0, q_ff};
   always_ff @(posedge clock) begin
      if (cmd.sum) begin
         if (triv_ff)                    flux_ff <= f0_ff;
         else if (neg_ff)
            flux_ff <= (q_ff[40] || q_ff > {9'd0, f0_ff}) ? 32'd0 : 32'(f0_ff - q_ff[31:0]);
         else if (q_ff[40] || fsum[41:32] != '0) flux_ff <= '1;
         else                            flux_ff <= fsum[31:0];
      end
   end

   // width product, truncated to Q32.16; it never exceeds 48 bits
   logic [63:0] wprod_ff;
   always_ff @(posedge clock) begin
      if (cmd.width_mul)
         wprod_ff <= (hi_ff > lo_ff) ? flux_ff * (hi_ff - lo_ff) : 64'd0;
   end

   // result register and pointer update
   logic [47:0] bf_ff;
   logic        oog_ff, end_ff;
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         oog_ff <= !status.bracket_ok;
         end_ff <= last_ff;
         bf_ff  <= status.bracket_ok ? wprod_ff[63:16] : 48'd0;
      end
   end
   always_comb begin
      sp_in = sp_ff;
      if (cmd.finish) begin
         if (last_ff)           sp_in = '0;
         else if (j_ff == '0)   sp_in = PW'(1);
         else                   sp_in = j_ff - 1'b1;
      end
   end

   assign rsp_bin_flux    = bf_ff;
   assign rsp_out_of_grid = oog_ff;
   assign rsp_run_end     = end_ff;
endmodule
`default_nettype wire

// ===== test/tb_spectrum_linear_rebin_core.sv =====
// testbench for spectrum_linear_rebin_core: loads grids, resamples bins and checks
// every result beat against an in-bench interpolation predictor
// depends on slr_pkg and the spectrum_linear_rebin_core rtl
`default_nettype none
module tb_spectrum_linear_rebin_core
   import slr_pkg::*;
;

   localparam int Depth       = 256;
   localparam int SettleCycles = 800;
   localparam longint CycleLimit = 6000000;
   localparam logic ActLoad = 1'b0;
   localparam logic ActBin  = 1'b1;

   typedef struct packed {
      logic [47:0] bin_flux;
      logic        out_of_grid;
      logic        run_end;
   } bin_result_type;

   logic        clock, reset;
   logic        req_valid, req_ready, req_action, req_last_bin;
   logic [7:0]  req_grid_index;
   logic [31:0] req_grid_energy_in, req_grid_flux_in, req_low_edge, req_high_edge;
   logic        rsp_valid, rsp_ready, rsp_out_of_grid, rsp_run_end;
   logic [47:0] rsp_bin_flux;
   logic        csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [1:0]  csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;

   // predictor state
   logic [31:0] grid_energy [Depth];
   logic [31:0] grid_flux   [Depth];
   logic [8:0]  scan_start;
   logic [7:0]  top_index;
   bin_result_type expected_bins [$];

   int     mismatches;
   int     idle_pct, stall_pct, hold_left;
   longint cycles;

   spectrum_linear_rebin_core dut (.*);

   // clock and cycle limit
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("spectrum_linear_rebin_core: mismatch");
         $finish;
      end
   end

   // flux at the midpoint, saturated to 32 bits
   function automatic logic [31:0] lerp_at_mid(logic [31:0] f0, logic [31:0] f1,
                                                logic [31:0] e0, logic [31:0] e1,
                                                logic [63:0] mid2);
      longint dt, dd, df;
      logic         neg;
      logic [127:0] a, b, d, q;
      dt = longint'(mid2) - 2 * longint'({32'b0, e0});
      dd = 2 * (longint'({32'b0, e1}) - longint'({32'b0, e0}));
      df = longint'({32'b0, f1}) - longint'({32'b0, f0});
      if (dd == 0 || df == 0 || dt == 0) return f0;
      neg = (df < 0) ^ (dt < 0) ^ (dd < 0);
      a = (df < 0) ? -df : df;
      b = (dt < 0) ? -dt : dt;
      d = (dd < 0) ? -dd : dd;
      q = (a * b) / d;
      if (neg) return (q >= (128'd1 << 40) || q > f0) ? 32'd0 : f0 - q[31:0];
      if (q >= (128'd1 << 40) || q + f0 > 128'hFFFF_FFFF) return 32'hFFFF_FFFF;
      return f0 + q[31:0];
   endfunction

   // one bin: scan, bracket, interpolate, scale by width
   function automatic bin_result_type predict_rebin_bin(logic [31:0] lo, logic [31:0] hi,
                                                         logic last);
      bin_result_type r;
      logic [63:0] mid2, prod;
      logic [31:0] f;
      int j;
      mid2 = {32'b0, lo} + {32'b0, hi};
      j = scan_start;
      while (j <= top_index && {31'b0, grid_energy[j], 1'b0} < mid2) j++;
      r = '0;
      r.run_end = last;
      if (j < 2 || j > top_index) begin
         r.out_of_grid = 1'b1;
      end else begin
         f = lerp_at_mid(grid_flux[j-1], grid_flux[j], grid_energy[j-1], grid_energy[j],
                         mid2);
         if (hi > lo) begin
            prod = ({32'b0, f} * {32'b0, hi - lo}) >> 16;
            r.bin_flux = (prod > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : prod[47:0];
         end
      end
      scan_start = last ? 9'd0 : (j == 0) ? 9'd1 : 9'(j - 1);
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [47:0] got, logic [47:0] want);
      $display("result beat %s: got %0h want %0h", field, got, want);
      mismatches++;
   endtask

   // one beat on the request channel, predicted when accepted
   task automatic send_item(logic act, logic [7:0] idx, logic [31:0] e, logic [31:0] f,
                            logic [31:0] lo, logic [31:0] hi, logic last);
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_action = act;
      req_grid_index = idx;
      req_grid_energy_in = e;
      req_grid_flux_in = f;
      req_low_edge = lo;
      req_high_edge = hi;
      req_last_bin = last;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      if (act == ActLoad) begin
         grid_energy[idx] = e;
         grid_flux[idx] = f;
      end else begin
         expected_bins.push_back(predict_rebin_bin(lo, hi, last));
      end
   endtask

   task automatic load_point(int idx, logic [31:0] e, logic [31:0] f);
      send_item(ActLoad, 8'(idx), e, f, $urandom, $urandom, 1'($urandom_range(0, 1)));
   endtask

   task automatic send_bin(logic [31:0] lo, logic [31:0] hi, logic last);
      send_item(ActBin, 8'($urandom), $urandom, $urandom, lo, hi, last);
   endtask

   // stop offering and wait until every result beat is back
   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      wait (expected_bins.size() == 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_last_index(logic [7:0] value);
      drain_results();
      @(negedge clock);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_paddr = 2'(RegIndexLastGrid * 4);
      csr_pwdata = {24'b0, value};
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      top_index = value;
   endtask

   // reset-time register value, extremes of fields, bracket corner cases
   task automatic test_directed();
      load_point(0, 32'h0000_0000, 32'hFFFF_FFFF);
      load_point(1, 32'hFFFF_FFFF, 32'h0000_0000);
      send_bin(32'h0, 32'h0, 1'b0);                   // lower bracket below one
      send_bin(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);   // midpoint at last index energy, lower bracket below one
      write_last_index(8'd4);
      load_point(0, 32'h0001_0000, 32'h0001_0000);
      load_point(1, 32'h0002_0000, 32'h0010_0000);
      load_point(2, 32'h0003_0000, 32'h0004_0000);
      load_point(3, 32'h0003_0000, 32'h0008_0000);    // flat step in energy
      load_point(4, 32'h0008_0000, 32'hFFFF_FFFF);
      send_bin(32'h0002_0000, 32'h0003_0000, 1'b0);   // midpoint between points one and two
      send_bin(32'h0002_0000, 32'h0003_8000, 1'b0);   // falling flux
      send_bin(32'h0003_0000, 32'h0003_0000, 1'b0);   // zero width, exact hit
      send_bin(32'h0004_0000, 32'h0002_0000, 1'b0);   // backward bin
      send_bin(32'h0000_0000, 32'h000F_FFFF, 1'b0);   // wide bin, large flux
      send_bin(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);   // wide bin, midpoint beyond last index
      send_bin(32'hF000_0000, 32'hFFFF_FFFF, 1'b1);   // beyond last index
      write_last_index(8'd0);                         // zero index used as given
      send_bin(32'h0000_0000, 32'h0000_0000, 1'b0);
      send_bin(32'h0002_0000, 32'h0004_0000, 1'b1);
   endtask

   // sorted grid of top+1 points, then ascending bins with some noise
   task automatic run_grid_phase(int top, int n_bins);
      logic [31:0] e, span, lo, hi, w;
      logic [63:0] center;
      write_last_index(8'(top));
      e = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32'hB000_0000)
                                      : $urandom_range(0, 32'h0001_0000);
      for (int i = 0; i <= top; i++) begin
         load_point(i, e, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h00FF_FFFF));
         if ($urandom_range(0, 15) != 0) e = e + $urandom_range(1, 32'h0004_0000);
      end
      span = e - grid_energy[0];
      center = grid_energy[0] - (span >> 3);
      for (int k = 0; k < n_bins; k++) begin
         center = center + $urandom_range(0, span / n_bins * 2 + 1);
         w = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 32'h0004_0000);
         lo = (center > w / 2) ? 32'(center - w / 2) : 32'h0;
         hi = (64'(lo) + w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : lo + w;
         case ($urandom_range(0, 9))
            0: send_bin($urandom, $urandom, 1'($urandom_range(0, 1)));
            1: load_point($urandom_range(top + 1, 255), $urandom, $urandom);
            default: send_bin(lo, hi, k == n_bins - 1);
         endcase
      end
   endtask

   task automatic test_random();
      int modes_idle[4] = '{0, 64, 0, 9};
      int modes_stall[4] = '{0, 0, 64, 9};
      for (int m = 0; m < 4; m++) begin
         idle_pct = modes_idle[m];
         stall_pct = modes_stall[m];
         for (int p = 0; p < 6; p++)
            run_grid_phase($urandom_range(2, 24), $urandom_range(10, 30));
      end
      idle_pct = 9;
      stall_pct = 9;
      run_grid_phase(255, 40);
      run_grid_phase(1, 10);
   endtask

   // receiver holds off long enough to back up the request channel
   task automatic test_backpressure();
      idle_pct = 0;
      stall_pct = 0;
      write_last_index(8'd6);
      for (int i = 0; i <= 6; i++) load_point(i, 32'h0001_0000 * (i + 1), $urandom);
      hold_left = 600;
      for (int k = 0; k < 20; k++)
         send_bin(32'h0001_0000 + k * 32'h4000, 32'h0002_0000 + k * 32'h4000, k == 19);
      drain_results();
   endtask

   // result ready, with long hold-off when requested
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready = 1'b0;
         hold_left--;
      end else begin
         rsp_ready = ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // compare each result beat with the oldest expectation
   always @(posedge clock) begin
      bin_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bins.size() == 0) begin
            $display("result beat with nothing expected");
            mismatches++;
         end else begin
            want = expected_bins.pop_front();
            if (rsp_bin_flux !== want.bin_flux)
               report_mismatch("bin_flux", rsp_bin_flux, want.bin_flux);
            if (rsp_out_of_grid !== want.out_of_grid)
               report_mismatch("out_of_grid", rsp_out_of_grid, want.out_of_grid);
            if (rsp_run_end !== want.run_end)
               report_mismatch("run_end", rsp_run_end, want.run_end);
         end
      end
   end

   initial begin
      cycles = 0;
      mismatches = 0;
      idle_pct = 0;
      stall_pct = 0;
      hold_left = 0;
      scan_start = '0;
      top_index = 8'd1;
      rsp_ready = 1'b0;
      req_valid = 1'b0;
      req_action = ActLoad;
      req_grid_index = '0;
      req_grid_energy_in = '0;
      req_grid_flux_in = '0;
      req_low_edge = '0;
      req_high_edge = '0;
      req_last_bin = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_backpressure();
      test_random();
      drain_results();
      if (mismatches == 0)
         $display("spectrum_linear_rebin_core: match");
      else
         $display("spectrum_linear_rebin_core: mismatch");
      $finish;
   end

endmodule
`default_nettype wire
